// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising edge of clk, off while arst_n is low.
`define MET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/met_pkg.sv -----
`default_nettype none

package met_pkg;

	localparam int MUL_DIGITS = 2;
	localparam int MAX_EXP = 16;
	localparam int CFG_W = 32;

	typedef enum logic [2:0] {
		CFG_CENTER_X   = 3'd0,
		CFG_CENTER_Y   = 3'd1,
		CFG_ZOOM       = 3'd2,
		CFG_ITER_EXP   = 3'd3,
		CFG_IMAGE_SIZE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
	} pixel_t;

	typedef struct packed {
		logic [3:0]  color;
		logic [16:0] iterations;
		logic        inside_res;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ITER,
		ST_DONE
	} state_t;

	// 15,7,14,6,... : even counts walk down from 15, odd ones down from 7
	function automatic logic [3:0] palette(input logic [3:0] idx);
		return {~idx[0], ~idx[3:1]};
	endfunction

endpackage

`default_nettype wire

// ----- sv/met_cell.sv -----
`default_nettype none

module met_cell #(
	parameter int IW  = 40,
	parameter int DW  = 20,
	parameter int BW  = 40,
	parameter int POS = 0,
	parameter bit TOP = 1'b0
) (
	input  logic                   clk,
	input  logic signed [IW-1:0]   a,
	input  logic        [BW-1:0]   b,
	input  logic signed [2*IW-1:0] acc_in,
	output logic signed [IW-1:0]   a_out,
	output logic        [BW-1:0]   b_out,
	output logic signed [2*IW-1:0] acc_out
);

	logic        [DW-1:0]   dig;
	logic signed [DW:0]     dig_s;
	logic signed [IW+DW:0]  pp;
	logic signed [2*IW-1:0] acc_n;

	always_comb begin
		dig   = b[POS*DW +: DW];
		// only the most significant digit carries the sign
		dig_s = TOP ? $signed({dig[DW-1], dig}) : $signed({1'b0, dig});
		pp    = a * dig_s;
		acc_n = acc_in + ((2*IW)'(pp) <<< (POS*DW));
	end

	always_ff @(posedge clk) begin
		a_out   <= a;
		b_out   <= b;
		acc_out <= acc_n;
	end

endmodule

`default_nettype wire

// ----- sv/met_mul.sv -----
`default_nettype none

module met_mul import met_pkg::*; #(
	parameter int IW = 40
) (
	input  logic                   clk,
	input  logic signed [IW-1:0]   a,
	input  logic signed [IW-1:0]   b,
	output logic signed [2*IW-1:0] prod
);

	localparam int DW = (IW + 1) / 2;
	localparam int BW = MUL_DIGITS * DW;

	logic signed [IW-1:0]   a_c   [MUL_DIGITS];
	logic        [BW-1:0]   b_c   [MUL_DIGITS];
	logic signed [2*IW-1:0] acc_c [MUL_DIGITS+1];

	assign a_c[0]   = a;
	assign b_c[0]   = BW'(b);
	assign acc_c[0] = '0;
	assign prod     = acc_c[MUL_DIGITS];

	// one digit of b per cell; each cell registers its partial sum, and the product leaves the last cell
	for (genvar k = 0; k < MUL_DIGITS; k++) begin : g_cell
		if (k < MUL_DIGITS - 1) begin : g_mid
			met_cell #(
				.IW(IW), .DW(DW), .BW(BW), .POS(k), .TOP(1'b0)
			) u_cell (
				.clk    (clk),
				.a      (a_c[k]),
				.b      (b_c[k]),
				.acc_in (acc_c[k]),
				.a_out  (a_c[k+1]),
				.b_out  (b_c[k+1]),
				.acc_out(acc_c[k+1])
			);
		end else begin : g_last
			met_cell #(
				.IW(IW), .DW(DW), .BW(BW), .POS(k), .TOP(1'b1)
			) u_cell (
				.clk    (clk),
				.a      (a_c[k]),
				.b      (b_c[k]),
				.acc_in (acc_c[k]),
				.a_out  (),
				.b_out  (),
				.acc_out(acc_c[k+1])
			);
		end
	end

endmodule

`default_nettype wire

// ----- sv/met_div.sv -----
`default_nettype none

module met_div #(
	parameter int NW = 41,
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic          rem_nz
);

	localparam int CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic [DW:0]   rem_n;
	logic          ge;

	// restoring division, one quotient bit per cycle, dividend shifted out MSB first
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, dvs_q};
		rem_n = ge ? trial - {1'b0, dvs_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= rem_n[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = |rem_q;

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time evaluator, one pixel at a time.
// Configuration: write cfg_data to register cfg_addr while cfg_we is high
// (0 center_x, 1 center_y, 2 zoom_level, 3 iteration_exponent, 4 image_size).
// Write only while no pixel is in flight and no result waits.
// Pixel channel: a transfer happens when pixel_valid is high and pixel_stall
// is low. pixel_stall stays high from the transfer until the result of that
// pixel has been loaded into the output register.
// Flow: the two coordinates are mapped by bit-serial dividers of NW bits
// (NW = FRAC_BITS + 2 + max(11, clog2(MAX_SIDE+1)), 41 by default), then each
// escape iteration runs through the two-cell multiplier chain and the
// update of z. pixel_stall falls in the same cycle that result_valid rises.
// Result channel: result holds until result_valid meets a low result_stall.
// A finished result waits in the output register; the next pixel is taken
// while it waits. A stalled result blocks only the load of the following one.
// Reset: registers go to center 0, zoom 1, exponent 8, size 120; no result
// is pending and the block is ready for a pixel.
`default_nettype none
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel import met_pkg::*; #(
	parameter int MAX_SIDE  = 1024,
	parameter int FRAC_BITS = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  pixel_t           pixel,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	localparam int IW  = FRAC_BITS + 12;
	localparam int SW  = $clog2(MAX_SIDE + 1);
	localparam int AW  = (SW > 11) ? SW : 11;
	localparam int NW  = AW + FRAC_BITS + 2;
	localparam int DVW = SW + 1;
	localparam int QW  = NW + 2;
	localparam int CW  = ((QW > 32) ? QW : 32) + 1;
	localparam int PW  = $clog2(MUL_DIGITS + 1);

	localparam logic signed [CW-1:0] SAT_HI = CW'(32'sh7FFF_FFFF);
	localparam logic signed [CW-1:0] SAT_LO = CW'(32'sh8000_0000);
	localparam logic signed [IW:0]   FOUR   = (IW+1)'(1) <<< (FRAC_BITS + 2);

	// configuration
	logic [31:0] center_x_q;
	logic [31:0] center_y_q;
	logic [4:0]  zoom_q;
	logic [4:0]  exp_q;
	logic [9:0]  size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			zoom_q     <= 5'd1;
			exp_q      <= 5'd8;
			size_q     <= 10'd120;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_CENTER_X:   center_x_q <= cfg_data[31:0];
				CFG_CENTER_Y:   center_y_q <= cfg_data[31:0];
				CFG_ZOOM:       zoom_q     <= cfg_data[4:0];
				CFG_ITER_EXP:   exp_q      <= cfg_data[4:0];
				CFG_IMAGE_SIZE: size_q     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [AW:0] offset(input logic [9:0] pos,
	                                             input logic [SW-1:0] n);
		return $signed({{(AW-10){1'b0}}, pos, 1'b0}) - $signed({{(AW+1-SW){1'b0}}, n});
	endfunction

	function automatic logic [IW-1:0] to_word(input logic signed [CW-1:0] c);
		logic signed [31:0]    s;
		logic signed [IW+31:0] e;
		if (c > SAT_HI) begin
			s = 32'sh7FFF_FFFF;
		end else if (c < SAT_LO) begin
			s = 32'sh8000_0000;
		end else begin
			s = c[31:0];
		end
		e = (IW+32)'(s);
		return e[IW-1:0];
	endfunction

	state_t state_q, state_d;

	logic          accept;
	logic          ld_coord;
	logic          step;
	logic          finish;
	logic          ld_out;
	logic          out_free;

	// pixel to dividend: num = w*(2*pos - n), den = 2*n, w = 2^(FRAC_BITS+2-sh)
	logic [15:0]         size_ext;
	logic [SW-1:0]       n_eff;
	logic [4:0]          sh;
	logic                w_zero;
	logic signed [AW:0]  m_x, m_y;
	logic [AW:0]         ma_x, ma_y;
	logic [NW-1:0]       dvd_x, dvd_y;
	logic [DVW-1:0]      dvs;

	always_comb begin
		size_ext = {6'd0, size_q};
		if (size_q == '0) begin
			n_eff = SW'(1);
		end else if (size_ext > 16'(MAX_SIDE)) begin
			n_eff = SW'(MAX_SIDE);
		end else begin
			n_eff = SW'(size_ext);
		end
		sh     = (zoom_q > 5'd1) ? zoom_q - 5'd1 : 5'd0;
		w_zero = {27'd0, sh} > 32'(FRAC_BITS + 2);
		m_x    = offset(pixel.col, n_eff);
		m_y    = offset(pixel.row, n_eff);
		ma_x   = m_x[AW] ? -m_x : m_x;
		ma_y   = m_y[AW] ? -m_y : m_y;
		dvd_x  = w_zero ? '0 : (NW'(ma_x[AW-1:0]) << (FRAC_BITS + 2)) >> sh;
		dvd_y  = w_zero ? '0 : (NW'(ma_y[AW-1:0]) << (FRAC_BITS + 2)) >> sh;
		dvs    = {n_eff, 1'b0};
	end

	logic          done_x, done_y, rnz_x, rnz_y;
	logic [NW-1:0] quo_x, quo_y;
	logic          div_done;

	met_div #(.NW(NW), .DW(DVW)) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dividend(dvd_x),
		.divisor (dvs),
		.done    (done_x),
		.quotient(quo_x),
		.rem_nz  (rnz_x)
	);

	met_div #(.NW(NW), .DW(DVW)) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dividend(dvd_y),
		.divisor (dvs),
		.done    (done_y),
		.quotient(quo_y),
		.rem_nz  (rnz_y)
	);

	assign div_done = done_x && done_y;

	logic                 neg_x_q, neg_y_q;
	logic [QW-1:0]        qm_x, qm_y, q_x, q_y;
	logic signed [CW-1:0] c_x, c_y;

	// floor of a negative quotient rounds the magnitude up
	always_comb begin
		qm_x = QW'(quo_x) + QW'(rnz_x && neg_x_q);
		qm_y = QW'(quo_y) + QW'(rnz_y && neg_y_q);
		q_x  = neg_x_q ? -qm_x : qm_x;
		q_y  = neg_y_q ? -qm_y : qm_y;
		c_x  = CW'($signed(center_x_q)) + CW'($signed(q_x));
		c_y  = CW'($signed(center_y_q)) + CW'($signed(q_y));
	end

	// iteration
	logic signed [IW-1:0]   zr_q, zi_q, cr_q, ci_q;
	logic [16:0]            it_q;
	logic [PW-1:0]          phase_q;
	logic signed [2*IW-1:0] prod_rr, prod_ii, prod_ri;
	logic signed [IW-1:0]   r2, i2, ri2, zr_n, zi_n;
	logic signed [IW:0]     mag2;
	logic                   escape;
	logic                   last_phase;
	logic [4:0]             ex;
	logic [16:0]            limit;
	logic                   at_limit;
	result_t                pend_q, res_q;
	logic                   result_valid_q;

	met_mul #(.IW(IW)) u_mul_rr (.clk(clk), .a(zr_q), .b(zr_q), .prod(prod_rr));
	met_mul #(.IW(IW)) u_mul_ii (.clk(clk), .a(zi_q), .b(zi_q), .prod(prod_ii));
	met_mul #(.IW(IW)) u_mul_ri (.clk(clk), .a(zr_q), .b(zi_q), .prod(prod_ri));

	always_comb begin
		r2         = prod_rr[FRAC_BITS +: IW];
		i2         = prod_ii[FRAC_BITS +: IW];
		ri2        = prod_ri[FRAC_BITS-1 +: IW];   // 2*zr*zi
		mag2       = (IW+1)'(r2) + (IW+1)'(i2);
		escape     = mag2 >= FOUR;
		zr_n       = r2 - i2 + cr_q;
		zi_n       = ri2 + ci_q;
		last_phase = phase_q == PW'(MUL_DIGITS);
		ex         = (exp_q > 5'(MAX_EXP)) ? 5'(MAX_EXP) : exp_q;
		limit      = 17'(1) << ex;
		at_limit   = it_q == limit;
	end

	assign out_free    = !result_valid_q || !result_stall;
	assign pixel_stall = state_q != ST_IDLE;
	assign accept      = pixel_valid && !pixel_stall;

	always_comb begin
		state_d  = state_q;
		ld_coord = 1'b0;
		step     = 1'b0;
		finish   = 1'b0;
		ld_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pixel_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ld_coord = 1'b1;
					state_d  = ST_ITER;
				end
			end
			ST_ITER: begin
				if (last_phase) begin
					if (at_limit || escape) begin
						finish  = 1'b1;
						state_d = ST_DONE;
					end else begin
						step = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= '0;
			it_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_coord) begin
				phase_q <= '0;
				it_q    <= '0;
			end else if (state_q == ST_ITER) begin
				phase_q <= last_phase ? '0 : phase_q + PW'(1);
				if (step) begin
					it_q <= it_q + 17'd1;
				end
			end
			if (ld_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_x_q <= m_x[AW];
			neg_y_q <= m_y[AW];
		end
		if (ld_coord) begin
			cr_q <= to_word(c_x);
			ci_q <= to_word(c_y);
			zr_q <= '0;
			zi_q <= '0;
		end else if (step) begin
			zr_q <= zr_n;
			zi_q <= zi_n;
		end
		if (finish) begin
			pend_q.color      <= at_limit ? 4'd0 : palette(it_q[3:0]);
			pend_q.iterations <= it_q;
			pend_q.inside_res <= at_limit;
		end
		if (ld_out) begin
			res_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = res_q;

	`MET_ASSERT(a_inside_count, (result_valid_q && res_q.inside_res) |-> (res_q.iterations == limit), "inside result without reaching the limit")
	`MET_ASSERT(a_inside_color, (result_valid_q && res_q.inside_res) |-> (res_q.color == 4'd0), "inside result with a nonzero color")
	`MET_ASSERT(a_iter_bound, (state_q == ST_ITER) |-> (it_q <= limit), "iteration count passed the limit")
	`MET_ASSERT_NEXT(a_coord_start, ld_coord, (state_q == ST_ITER) && (it_q == '0) && (phase_q == '0), "iteration did not start clean")

endmodule

`default_nettype wire

// ----- verif/mandelbrot_escape_time_pixel_tb.sv -----
`default_nettype none

module mandelbrot_escape_time_pixel_tb;
	import met_pkg::*;

	localparam int SIDE_MAX = 1024;
	localparam int FRAC = 28;
	localparam int WORD = FRAC + 12;
	localparam longint CYCLE_LIMIT = 64'd500000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	pixel_t pixel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// view settings mirrored from the register writes
	logic [31:0] view_cx = 0, view_cy = 0;
	logic [4:0] view_zoom = 5'd1, view_exp = 5'd8;
	logic [9:0] view_size = 10'd120;

	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_recv = 1'b0;
	longint cycles = 0;
	int pixels_sent = 0;

	always #4 clk = ~clk;

	mandelbrot_escape_time_pixel dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel(pixel), .result_valid(result_valid), .result_stall(result_stall),
		.result(result));

	function automatic logic signed [WORD-1:0] sq_floor(logic signed [WORD-1:0] a,
			logic signed [WORD-1:0] b, int sh);
		logic signed [2*WORD-1:0] prod;
		prod = $signed(a) * $signed(b);
		return WORD'(prod >>> sh);
	endfunction

	function automatic logic signed [WORD-1:0] map_coord(logic [31:0] ctr, int pos,
			longint w, longint n);
		longint num, d, q, c;
		num = 2 * longint'(pos) * w - w * n;
		d = 2 * n;
		q = num / d;
		if (num % d != 0 && num < 0) q--;
		c = longint'($signed(ctr)) + q;
		if (c > 64'sd2147483647) c = 64'sd2147483647;
		if (c < -64'sd2147483648) c = -64'sd2147483648;
		return WORD'(c);
	endfunction

	function automatic result_t escape_time(pixel_t p);
		longint n, w;
		int ex;
		int unsigned lim, cnt;
		logic signed [WORD-1:0] cr, ci, zr, zi, r2, i2, ri2;
		logic signed [WORD+1:0] mag;
		result_t r;
		n = view_size == 0 ? 1 : view_size;
		if (n > SIDE_MAX) n = SIDE_MAX;
		w = (longint'(4) << FRAC) >>> (view_zoom > 1 ? view_zoom - 1 : 0);
		ex = view_exp > MAX_EXP ? MAX_EXP : view_exp;
		lim = 1 << ex;
		cr = map_coord(view_cx, p.col, w, n);
		ci = map_coord(view_cy, p.row, w, n);
		zr = 0; zi = 0; cnt = 0;
		while (cnt != lim) begin
			r2 = sq_floor(zr, zr, FRAC);
			i2 = sq_floor(zi, zi, FRAC);
			mag = (WORD+2)'(r2) + (WORD+2)'(i2);
			if (mag >= ((WORD+2)'(4) << FRAC)) break;
			ri2 = sq_floor(zr, zi, FRAC - 1);
			zr = r2 - i2 + cr;
			zi = ri2 + ci;
			cnt++;
		end
		r.inside_res = (cnt == lim);
		r.iterations = 17'(cnt);
		r.color = r.inside_res ? 4'd0 : palette(4'(cnt));
		return r;
	endfunction

	class pixel_scoreboard;
		result_t pending[$];
		int mismatches = 0;
		int checked = 0;

		function void note_pixel(pixel_t p);
			pending.push_back(escape_time(p));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.color !== want.color || got.iterations !== want.iterations ||
					got.inside_res !== want.inside_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	pixel_scoreboard sb = new();

	// monitor: sample at the edge, before the nonblocking updates land
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) sb.note_pixel(pixel);
			if (result_valid && !result_stall) sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (hold_recv) result_stall <= 1'b1;
		else result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CENTER_X: view_cx = v;
			CFG_CENTER_Y: view_cy = v;
			CFG_ZOOM: view_zoom = v[4:0];
			CFG_ITER_EXP: view_exp = v[4:0];
			CFG_IMAGE_SIZE: view_size = v[9:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// valid stays up between back-to-back transfers
	task automatic send_pixel(logic [9:0] c, logic [9:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= '{col: c, row: r};
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic idle_sender();
		pixel_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_view();
		int z;
		z = $urandom_range(9);
		drain();
		write_reg(CFG_CENTER_X, z < 3 ? $urandom : 32'($signed($urandom_range(0, 1<<30)))
			- 32'sd536870912);
		write_reg(CFG_CENTER_Y, z < 3 ? $urandom
			: 32'($urandom_range(0, 1 << 29)) - 32'd268435456);
		write_reg(CFG_ZOOM, z < 2 ? $urandom_range(31) : $urandom_range(0, 6));
		write_reg(CFG_ITER_EXP, $urandom_range(9) == 0 ? $urandom_range(31)
			: $urandom_range(0, 7));
		write_reg(CFG_IMAGE_SIZE, $urandom_range(4) == 0 ? $urandom_range(1023)
			: $urandom_range(0, 64));
	endtask

	task automatic random_pixels(int count);
		int sz;
		for (int i = 0; i < count; i++) begin
			sz = view_size == 0 ? 1 : view_size;
			if ($urandom_range(9) == 0) send_pixel(10'($urandom), 10'($urandom));
			else send_pixel(10'($urandom_range(sz - 1)), 10'($urandom_range(sz - 1)));
		end
		idle_sender();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, center, beyond the image, each exponent edge
		send_pixel(0, 0);
		send_pixel(60, 60);
		send_pixel(119, 119);
		send_pixel(1023, 1023);
		send_pixel(1023, 0);
		send_pixel(0, 1023);
		idle_sender();
		drain();
		write_reg(CFG_ITER_EXP, 0);
		write_reg(CFG_IMAGE_SIZE, 0);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		idle_sender();
		drain();
		write_reg(CFG_ITER_EXP, 31);
		write_reg(CFG_IMAGE_SIZE, 1023);
		write_reg(CFG_ZOOM, 0);
		write_reg(CFG_CENTER_X, 32'h8000_0000);
		write_reg(CFG_CENTER_Y, 32'h7fff_ffff);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(511, 511);
		idle_sender();
		drain();
		// deep zoom near a point inside the set, full 2^16 limit once
		write_reg(CFG_CENTER_X, 32'hf800_0000);
		write_reg(CFG_CENTER_Y, 32'h0);
		write_reg(CFG_ZOOM, 24);
		write_reg(CFG_IMAGE_SIZE, 1);
		send_pixel(0, 0);
		idle_sender();
		drain();
		write_reg(CFG_ZOOM, 31);
		write_reg(CFG_ITER_EXP, 4);
		write_reg(CFG_IMAGE_SIZE, 1024 - 1);
		send_pixel(512, 512);
		send_pixel(1, 1022);
		idle_sender();
		drain();
		write_reg(CFG_ITER_EXP, 16);
		write_reg(CFG_ZOOM, 1);
		write_reg(CFG_CENTER_X, 32'hf800_0000);
		send_pixel(0, 0);
		idle_sender();

		// back-pressure: receiver holds while pixels keep coming
		drain();
		write_reg(CFG_ITER_EXP, 5);
		write_reg(CFG_IMAGE_SIZE, 16);
		write_reg(CFG_CENTER_X, 32'hf000_0000);
		write_reg(CFG_ZOOM, 2);
		hold_recv = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_recv = 1'b0;
			end
			random_pixels(6);
		join

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 16 : (ph == 1 ? 70 : 0);
			recv_idle_pct = ph == 0 ? 70 : (ph == 1 ? 16 : 0);
			for (int k = 0; k < 6; k++) begin
				random_view();
				random_pixels(30);
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("%0d pixels sent, %0d results checked over varied views, sizes,",
			pixels_sent, sb.checked);
		$display("zooms and iteration limits with idling and back-pressure");
		if (sb.mismatches == 0 && sb.pending.size() == 0) $display("== PASS ==");
		else begin
			$display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/met_pkg.sv
sv/met_cell.sv
sv/met_mul.sv
sv/met_div.sv
sv/mandelbrot_escape_time_pixel.sv
verif/mandelbrot_escape_time_pixel_tb.sv
